// ===== rtl/core/page_frame_victim_selector_assert.svh =====
// assertion macros for the rtl
`ifndef PAGE_FRAME_VICTIM_SELECTOR_ASSERT_SVH
`define PAGE_FRAME_VICTIM_SELECTOR_ASSERT_SVH

// generic form: explicit clock and active-low reset
`define PFVS_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// block clock and reset
`define PFVS_ASSERT(label, prop, msg) \
    `PFVS_ASSERT_CLK(label, aclk, aresetn, prop, msg)

`endif

// ===== rtl/core/pfvs_pkg.sv =====
`default_nettype none

package pfvs_pkg;

    localparam int PAGE_W    = 10;
    localparam int FRAME_W   = 5;
    localparam int STAMP_W   = 32;
    localparam int MOD_STEPS = 2;
    localparam int MOD_CNT_W = $clog2(MOD_STEPS);

    localparam logic [MOD_CNT_W-1:0] MOD_LAST = MOD_CNT_W'(MOD_STEPS - 1);

    localparam logic OP_FAULT = 1'b0;
    localparam logic OP_TOUCH = 1'b1;

    localparam logic POLICY_FIFO = 1'b0;
    localparam logic POLICY_LRU  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_SCAN,
        ST_FETCH,
        ST_WRITE,
        ST_RESP
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/page_frame_victim_selector.sv =====
// channel  | ports                                                | direction
// s_       | s_valid s_ready s_opcode s_virtual_page s_touched_frame | in
// m_       | m_valid m_ready m_victim_frame m_swap_out m_evicted_page | out
// cfg_     | cfg_we cfg_wdata (policy_mode)                       | in
//
// steps per item, from the transfer until the block is idle again:
// touch: response state, which loads the result register once the output is free
// fault, fifo: page modulo (quotient, then remainder), owner read, write back, result
// fault, lru: page modulo, stamp scan to the first unused frame, else over all frames, then as fifo
// synchronous active-low reset; no ram clearing pass, per-frame used flops mask the rams
// one item in flight; a result held at the output keeps the next item in its response state
`default_nettype none

`include "page_frame_victim_selector_assert.svh"

module page_frame_victim_selector #(
    parameter int FRAMES        = 32,
    parameter int VIRTUAL_PAGES = 1024
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,

    input  wire logic                           cfg_we,
    input  wire logic                           cfg_wdata,

    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic                           s_opcode,
    input  wire logic [pfvs_pkg::PAGE_W-1:0]    s_virtual_page,
    input  wire logic [pfvs_pkg::FRAME_W-1:0]   s_touched_frame,

    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic      [pfvs_pkg::FRAME_W-1:0]   m_victim_frame,
    output logic                                m_swap_out,
    output logic      [pfvs_pkg::PAGE_W-1:0]    m_evicted_page
);

    localparam int FW = $clog2(FRAMES);
    localparam int OW = $clog2(VIRTUAL_PAGES);
    localparam int CW = $clog2(FRAMES + 1);
    localparam int SW = pfvs_pkg::STAMP_W;
    localparam int PW = pfvs_pkg::PAGE_W;

    // reciprocal of VIRTUAL_PAGES, exact for every PW-bit page
    localparam int MOD_K = PW + $clog2(VIRTUAL_PAGES);
    localparam int MOD_M = ((1 << MOD_K) + VIRTUAL_PAGES - 1) / VIRTUAL_PAGES;

    function automatic logic [FW-1:0] step_frame(input logic [FW-1:0] f);
        return (f == FW'(FRAMES - 1)) ? '0 : FW'(f + 1'b1);
    endfunction

    pfvs_pkg::state_t state_reg, state_next;

    logic                        policy_reg;
    logic [FRAMES-1:0]           used_reg, used_next;
    logic [FW-1:0]               rot_reg, rot_next;
    logic [FW-1:0]               last_reg, last_next;
    logic                        last_known_reg, last_known_next;
    logic [SW-1:0]               stamp_cnt_reg, stamp_cnt_next;
    logic                        m_valid_reg, m_valid_next;

    logic [PW-1:0]               page_sh_reg, page_sh_next;
    logic [PW-1:0]               mod_quot_reg, mod_quot_next;
    logic [PW-1:0]               mod_rem_reg, mod_rem_next;
    logic [pfvs_pkg::MOD_CNT_W-1:0] mod_cnt_reg, mod_cnt_next;
    logic [CW-1:0]               scan_cnt_reg, scan_cnt_next;
    logic                        cmp_vld_reg, cmp_vld_next;
    logic [FW-1:0]               cmp_idx_reg, cmp_idx_next;
    logic [FW-1:0]               best_idx_reg, best_idx_next;
    logic [SW-1:0]               best_stamp_reg, best_stamp_next;
    logic                        have_reg, have_next;
    logic [FW-1:0]               victim_reg, victim_next;
    logic [pfvs_pkg::FRAME_W-1:0] res_frame_reg, res_frame_next;
    logic                        res_swap_reg, res_swap_next;
    logic [PW-1:0]               res_evicted_reg, res_evicted_next;
    logic [pfvs_pkg::FRAME_W-1:0] m_frame_reg, m_frame_next;
    logic                        m_swap_reg, m_swap_next;
    logic [PW-1:0]               m_evicted_reg, m_evicted_next;

    logic          s_xfer;
    logic          out_free;
    logic          touch_in_range;
    logic          mod_last;
    logic          scan_issue;
    logic          scan_hit_free;
    logic          scan_done;
    logic          fifo_skip;
    logic [FW-1:0] fifo_pick;
    logic [SW-1:0] stamp_adv;
    logic [31:0]   mod_quot_full;
    logic [31:0]   mod_diff;
    logic [31:0]   tframe_ext;
    logic [31:0]   victim_ext;
    logic [31:0]   rem_ext;
    logic [31:0]   owner_ext;

    logic          stamp_we;
    logic [FW-1:0] stamp_waddr;
    logic [FW-1:0] stamp_raddr;
    logic [SW-1:0] stamp_rdata;
    logic          owner_we;
    logic [OW-1:0] owner_wdata;
    logic [OW-1:0] owner_rdata;

    assign s_ready  = (state_reg == pfvs_pkg::ST_IDLE);
    assign s_xfer   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign m_valid        = m_valid_reg;
    assign m_victim_frame = m_frame_reg;
    assign m_swap_out     = m_swap_reg;
    assign m_evicted_page = m_evicted_reg;

    assign tframe_ext     = 32'(s_touched_frame);
    assign touch_in_range = tframe_ext < 32'(FRAMES);
    assign stamp_adv      = (stamp_cnt_reg == '1) ? stamp_cnt_reg : SW'(stamp_cnt_reg + 1'b1);

    // page modulo VIRTUAL_PAGES: the quotient is registered first, then the remainder is formed from it
    assign mod_quot_full = (32'(page_sh_reg) * 32'(MOD_M)) >> MOD_K;
    assign mod_diff      = 32'(page_sh_reg) - 32'(mod_quot_reg) * 32'(VIRTUAL_PAGES);
    assign mod_last      = (mod_cnt_reg == pfvs_pkg::MOD_LAST);

    assign fifo_skip = last_known_reg && (rot_reg == last_reg);
    assign fifo_pick = fifo_skip ? step_frame(rot_reg) : rot_reg;

    assign scan_issue    = 32'(scan_cnt_reg) < 32'(FRAMES);
    assign scan_hit_free = cmp_vld_reg && !used_reg[cmp_idx_reg];
    assign scan_done     = !scan_issue && !cmp_vld_reg;

    assign victim_ext = 32'(victim_reg);
    assign rem_ext    = 32'(mod_rem_reg);
    assign owner_ext  = 32'(owner_rdata);

    // ram ports
    assign stamp_raddr = scan_cnt_reg[FW-1:0];
    assign stamp_we    = (s_xfer && (s_opcode == pfvs_pkg::OP_TOUCH) && touch_in_range)
                         || (state_reg == pfvs_pkg::ST_WRITE);
    assign stamp_waddr = (state_reg == pfvs_pkg::ST_WRITE) ? victim_reg : tframe_ext[FW-1:0];
    assign owner_we    = (state_reg == pfvs_pkg::ST_WRITE);
    assign owner_wdata = rem_ext[OW-1:0];

    pfvs_ram #(
        .WIDTH (SW),
        .DEPTH (FRAMES)
    ) u_stamp_ram (
        .aclk  (aclk),
        .we    (stamp_we),
        .waddr (stamp_waddr),
        .wdata (stamp_cnt_reg),
        .raddr (stamp_raddr),
        .rdata (stamp_rdata)
    );

    pfvs_ram #(
        .WIDTH (OW),
        .DEPTH (FRAMES)
    ) u_owner_ram (
        .aclk  (aclk),
        .we    (owner_we),
        .waddr (victim_reg),
        .wdata (owner_wdata),
        .raddr (victim_reg),
        .rdata (owner_rdata)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            pfvs_pkg::ST_IDLE: begin
                if (s_xfer) begin
                    state_next = (s_opcode == pfvs_pkg::OP_TOUCH)
                                 ? pfvs_pkg::ST_RESP : pfvs_pkg::ST_MOD;
                end
            end
            pfvs_pkg::ST_MOD: begin
                if (mod_last) begin
                    state_next = (policy_reg == pfvs_pkg::POLICY_LRU)
                                 ? pfvs_pkg::ST_SCAN : pfvs_pkg::ST_FETCH;
                end
            end
            pfvs_pkg::ST_SCAN: begin
                if (scan_hit_free || scan_done) begin
                    state_next = pfvs_pkg::ST_FETCH;
                end
            end
            pfvs_pkg::ST_FETCH: state_next = pfvs_pkg::ST_WRITE;
            pfvs_pkg::ST_WRITE: state_next = pfvs_pkg::ST_RESP;
            pfvs_pkg::ST_RESP: begin
                if (out_free) begin
                    state_next = pfvs_pkg::ST_IDLE;
                end
            end
            default: state_next = pfvs_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        used_next        = used_reg;
        rot_next         = rot_reg;
        last_next        = last_reg;
        last_known_next  = last_known_reg;
        stamp_cnt_next   = stamp_cnt_reg;
        page_sh_next     = page_sh_reg;
        mod_quot_next    = mod_quot_reg;
        mod_rem_next     = mod_rem_reg;
        mod_cnt_next     = mod_cnt_reg;
        scan_cnt_next    = scan_cnt_reg;
        cmp_vld_next     = 1'b0;
        cmp_idx_next     = cmp_idx_reg;
        best_idx_next    = best_idx_reg;
        best_stamp_next  = best_stamp_reg;
        have_next        = have_reg;
        victim_next      = victim_reg;
        res_frame_next   = res_frame_reg;
        res_swap_next    = res_swap_reg;
        res_evicted_next = res_evicted_reg;
        m_frame_next     = m_frame_reg;
        m_swap_next      = m_swap_reg;
        m_evicted_next   = m_evicted_reg;
        m_valid_next     = m_valid_reg && !m_ready;

        unique case (state_reg)
            pfvs_pkg::ST_IDLE: begin
                if (s_xfer) begin
                    page_sh_next     = s_virtual_page;
                    mod_rem_next     = '0;
                    mod_cnt_next     = '0;
                    res_frame_next   = s_touched_frame;
                    res_swap_next    = 1'b0;
                    res_evicted_next = '0;
                    if ((s_opcode == pfvs_pkg::OP_TOUCH) && touch_in_range) begin
                        stamp_cnt_next = stamp_adv;
                    end
                end
            end
            pfvs_pkg::ST_MOD: begin
                mod_cnt_next = pfvs_pkg::MOD_CNT_W'(mod_cnt_reg + 1'b1);
                if (mod_last) begin
                    mod_rem_next  = mod_diff[PW-1:0];
                    scan_cnt_next = '0;
                    have_next     = 1'b0;
                    if (policy_reg != pfvs_pkg::POLICY_LRU) begin
                        victim_next = fifo_pick;
                        rot_next    = step_frame(fifo_pick);
                    end
                end else begin
                    mod_quot_next = mod_quot_full[PW-1:0];
                end
            end
            pfvs_pkg::ST_SCAN: begin
                if (cmp_vld_reg && (!have_reg || (stamp_rdata < best_stamp_reg))) begin
                    best_idx_next   = cmp_idx_reg;
                    best_stamp_next = stamp_rdata;
                    have_next       = 1'b1;
                end
                if (scan_hit_free) begin
                    victim_next = cmp_idx_reg;
                end else if (scan_done) begin
                    victim_next = best_idx_reg;
                end else if (scan_issue) begin
                    cmp_vld_next  = 1'b1;
                    cmp_idx_next  = scan_cnt_reg[FW-1:0];
                    scan_cnt_next = CW'(scan_cnt_reg + 1'b1);
                end
            end
            pfvs_pkg::ST_FETCH: begin
                // owner ram read of the victim in flight
            end
            pfvs_pkg::ST_WRITE: begin
                res_frame_next   = victim_ext[pfvs_pkg::FRAME_W-1:0];
                res_swap_next    = used_reg[victim_reg];
                res_evicted_next = used_reg[victim_reg] ? owner_ext[PW-1:0] : '0;
                used_next[victim_reg] = 1'b1;
                last_next        = victim_reg;
                last_known_next  = 1'b1;
                stamp_cnt_next   = stamp_adv;
            end
            pfvs_pkg::ST_RESP: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_frame_next   = res_frame_reg;
                    m_swap_next    = res_swap_reg;
                    m_evicted_next = res_evicted_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= pfvs_pkg::ST_IDLE;
            policy_reg     <= pfvs_pkg::POLICY_FIFO;
            used_reg       <= '0;
            rot_reg        <= '0;
            last_reg       <= '0;
            last_known_reg <= 1'b0;
            stamp_cnt_reg  <= '0;
            m_valid_reg    <= 1'b0;
            cmp_vld_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            if (cfg_we) begin
                policy_reg <= cfg_wdata;
            end
            used_reg       <= used_next;
            rot_reg        <= rot_next;
            last_reg       <= last_next;
            last_known_reg <= last_known_next;
            stamp_cnt_reg  <= stamp_cnt_next;
            m_valid_reg    <= m_valid_next;
            cmp_vld_reg    <= cmp_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        page_sh_reg     <= page_sh_next;
        mod_quot_reg    <= mod_quot_next;
        mod_rem_reg     <= mod_rem_next;
        mod_cnt_reg     <= mod_cnt_next;
        scan_cnt_reg    <= scan_cnt_next;
        cmp_idx_reg     <= cmp_idx_next;
        best_idx_reg    <= best_idx_next;
        best_stamp_reg  <= best_stamp_next;
        have_reg        <= have_next;
        victim_reg      <= victim_next;
        res_frame_reg   <= res_frame_next;
        res_swap_reg    <= res_swap_next;
        res_evicted_reg <= res_evicted_next;
        m_frame_reg     <= m_frame_next;
        m_swap_reg      <= m_swap_next;
        m_evicted_reg   <= m_evicted_next;
    end

    `PFVS_ASSERT(a_victim_marked_used, (state_reg == pfvs_pkg::ST_WRITE) |=> used_reg[$past(victim_reg)], "victim frame not marked used after write back")
    `PFVS_ASSERT(a_stamp_monotonic, $past(aresetn) |-> (stamp_cnt_reg >= $past(stamp_cnt_reg)), "stamp counter went backward")
    `PFVS_ASSERT(a_scan_in_range, cmp_vld_reg |-> (32'(cmp_idx_reg) < 32'(FRAMES)), "scan compare on frame out of range")
    `PFVS_ASSERT(a_result_from_resp, $rose(m_valid_reg) |-> ($past(state_reg) == pfvs_pkg::ST_RESP), "result raised outside response state")
    `PFVS_ASSERT(a_write_after_fetch, (state_reg == pfvs_pkg::ST_WRITE) |-> ($past(state_reg) == pfvs_pkg::ST_FETCH), "write back without owner fetch")

endmodule

`default_nettype wire

// ===== rtl/core/pfvs_ram.sv =====
`default_nettype none

module pfvs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== sim/page_frame_victim_selector_tb.sv =====
`default_nettype none

module page_frame_victim_selector_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAMES = 32;
    localparam int VPAGES = 1024;

    typedef struct packed {
        logic                              opcode;
        logic [pfvs_pkg::PAGE_W-1:0]       page;
        logic [pfvs_pkg::FRAME_W-1:0]      frame;
    } request_t;

    typedef struct packed {
        logic [pfvs_pkg::FRAME_W-1:0]      frame;
        logic                              swap;
        logic [pfvs_pkg::PAGE_W-1:0]       evicted;
    } outcome_t;

    logic                                aclk           = 1'b0;
    logic                                aresetn        = 1'b0;
    logic                                cfg_we         = 1'b0;
    logic                                cfg_wdata      = 1'b0;
    logic                                s_valid        = 1'b0;
    logic                                s_ready;
    logic                                s_opcode       = 1'b0;
    logic [pfvs_pkg::PAGE_W-1:0]         s_virtual_page = '0;
    logic [pfvs_pkg::FRAME_W-1:0]        s_touched_frame = '0;
    logic                                m_valid;
    logic                                m_ready        = 1'b0;
    logic [pfvs_pkg::FRAME_W-1:0]        m_victim_frame;
    logic                                m_swap_out;
    logic [pfvs_pkg::PAGE_W-1:0]         m_evicted_page;

    request_t  request_q[$];
    outcome_t  pending_results[$];
    int        mismatch_count = 0;
    bit        send_gaps = 1'b1;
    bit        take_gaps = 1'b1;
    int        hold_request = 0;
    int        hold_left = 0;

    // mirror of the frame table
    logic         policy_shadow = pfvs_pkg::POLICY_FIFO;
    logic         slot_used  [FRAMES] = '{default: 1'b0};
    logic         slot_valid [FRAMES] = '{default: 1'b0};
    logic [31:0]  slot_stamp [FRAMES] = '{default: 32'd0};
    logic [pfvs_pkg::PAGE_W-1:0] slot_page [FRAMES] = '{default: '0};
    int unsigned  fifo_ptr = 0;
    int unsigned  newest_frame = 0;
    logic         newest_known = 1'b0;
    logic [31:0]  use_clock = 32'd0;

    page_frame_victim_selector #(
        .FRAMES        (FRAMES),
        .VIRTUAL_PAGES (VPAGES)
    ) u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_virtual_page  (s_virtual_page),
        .s_touched_frame (s_touched_frame),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_victim_frame  (m_victim_frame),
        .m_swap_out      (m_swap_out),
        .m_evicted_page  (m_evicted_page)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic outcome_t select_frame(input request_t req);
        outcome_t     res;
        int unsigned  victim;
        logic [31:0]  best;
        logic         found;
        logic         free_hit;
        res = '0;
        if (req.opcode == pfvs_pkg::OP_TOUCH) begin
            if (req.frame < FRAMES) begin
                slot_stamp[req.frame] = use_clock;
                if (use_clock != '1) use_clock++;
            end
            res.frame = req.frame;
            return res;
        end
        victim = 0;
        if (policy_shadow == pfvs_pkg::POLICY_LRU) begin
            best = '1;
            found = 1'b0;
            free_hit = 1'b0;
            for (int i = 0; i < FRAMES; i++) begin
                if (!free_hit) begin
                    if (!slot_used[i] || !slot_valid[i]) begin
                        victim = i;
                        free_hit = 1'b1;
                    end else if (!found || slot_stamp[i] < best) begin
                        best = slot_stamp[i];
                        victim = i;
                        found = 1'b1;
                    end
                end
            end
        end else begin
            // step past the frame loaded last
            if (newest_known && fifo_ptr == newest_frame) fifo_ptr = (fifo_ptr + 1) % FRAMES;
            victim = fifo_ptr;
            fifo_ptr = (fifo_ptr + 1) % FRAMES;
        end
        if (slot_used[victim]) begin
            res.swap = 1'b1;
            res.evicted = slot_page[victim];
        end
        slot_used[victim] = 1'b1;
        slot_valid[victim] = 1'b1;
        slot_page[victim] = pfvs_pkg::PAGE_W'(req.page % VPAGES);
        slot_stamp[victim] = use_clock;
        if (use_clock != '1) use_clock++;
        newest_frame = victim;
        newest_known = 1'b1;
        res.frame = pfvs_pkg::FRAME_W'(victim);
        return res;
    endfunction

    // request driver: predicts each transfer and offers the next request
    always @(posedge aclk) begin
        request_t head;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                head = request_q.pop_front();
                pending_results.push_back(select_frame(head));
            end
            if (!s_valid || s_ready) begin
                if (request_q.size() != 0 && !(send_gaps && $urandom_range(99) < 26)) begin
                    s_valid         <= 1'b1;
                    s_opcode        <= request_q[0].opcode;
                    s_virtual_page  <= request_q[0].page;
                    s_touched_frame <= request_q[0].frame;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else begin
            m_ready <= !(take_gaps && $urandom_range(99) < 26);
        end
    end

    always @(posedge aclk) begin
        outcome_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: frame=%0d swap=%0d page=%0d",
                             m_victim_frame, m_swap_out, m_evicted_page);
            end else begin
                want = pending_results.pop_front();
                if (m_victim_frame !== want.frame || m_swap_out !== want.swap ||
                    m_evicted_page !== want.evicted) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected frame=%0d swap=%0d page=%0d, got frame=%0d swap=%0d page=%0d",
                                 want.frame, want.swap, want.evicted,
                                 m_victim_frame, m_swap_out, m_evicted_page);
                end
            end
        end
    end

    task automatic send_item(input logic op, input logic [pfvs_pkg::PAGE_W-1:0] page,
                             input logic [pfvs_pkg::FRAME_W-1:0] frame);
        request_t req;
        req.opcode = op;
        req.page = page;
        req.frame = frame;
        request_q.push_back(req);
        while (request_q.size() > 1) @(posedge aclk);
    endtask

    task automatic send_random(input int fault_pct);
        logic [pfvs_pkg::PAGE_W-1:0] page;
        page = pfvs_pkg::PAGE_W'($urandom_range(VPAGES - 1));
        if ($urandom_range(9) == 0) page = $urandom_range(1) ? '1 : '0;
        send_item(($urandom_range(99) < fault_pct) ? pfvs_pkg::OP_FAULT : pfvs_pkg::OP_TOUCH,
                  page, pfvs_pkg::FRAME_W'($urandom_range(FRAMES - 1)));
    endtask

    task automatic wait_idle();
        while (request_q.size() != 0 || pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic set_policy(input logic mode);
        wait_idle();
        cfg_wdata <= mode;
        cfg_we    <= 1'b1;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        policy_shadow = mode;
    endtask

    // fifo right after reset, before any frame was loaded
    task automatic test_fifo_from_reset();
        send_item(pfvs_pkg::OP_FAULT, '0, '0);
        send_item(pfvs_pkg::OP_FAULT, '1, '1);
        send_item(pfvs_pkg::OP_TOUCH, '0, '0);
        send_item(pfvs_pkg::OP_TOUCH, '0, '1);
        send_item(pfvs_pkg::OP_FAULT, 10'h155, 5'h0a);
        send_item(pfvs_pkg::OP_TOUCH, '1, 5'h15);
    endtask

    // lru load leaves the rotate pointer on the newest frame
    task automatic test_policy_handover();
        set_policy(pfvs_pkg::POLICY_LRU);
        send_item(pfvs_pkg::OP_FAULT, 10'h2aa, 5'h11);
        set_policy(pfvs_pkg::POLICY_FIFO);
        send_item(pfvs_pkg::OP_FAULT, '1, '0);
        send_item(pfvs_pkg::OP_FAULT, 10'd7, '0);
    endtask

    task automatic test_lru_directed();
        set_policy(pfvs_pkg::POLICY_LRU);
        send_item(pfvs_pkg::OP_TOUCH, '0, '1);
        send_item(pfvs_pkg::OP_FAULT, '0, '0);
        send_item(pfvs_pkg::OP_FAULT, '1, '0);
        send_item(pfvs_pkg::OP_TOUCH, '0, 5'd0);
        send_item(pfvs_pkg::OP_FAULT, 10'd512, '0);
        send_item(pfvs_pkg::OP_TOUCH, '0, 5'd4);
        send_item(pfvs_pkg::OP_FAULT, 10'd1, '1);
        send_item(pfvs_pkg::OP_TOUCH, 10'h3c3, 5'd2);
    endtask

    // result side held off while requests keep coming
    task automatic test_backpressure();
        hold_request = 400;
        repeat (12) send_random(60);
        wait_idle();
        repeat (20) send_random(50);
        wait_idle();
    endtask

    task automatic test_back_to_back();
        send_gaps = 1'b0;
        take_gaps = 1'b0;
        repeat (80) send_random(50);
        wait_idle();
        send_gaps = 1'b1;
        take_gaps = 1'b1;
    endtask

    task automatic test_random_phases();
        int fault_pct;
        for (int phase = 0; phase < 10; phase++) begin
            set_policy(phase % 2 ? pfvs_pkg::POLICY_FIFO : pfvs_pkg::POLICY_LRU);
            fault_pct = $urandom_range(85, 25);
            repeat (100) send_random(fault_pct);
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_fifo_from_reset();
        test_policy_handover();
        test_lru_directed();
        test_backpressure();
        test_back_to_back();
        test_random_phases();
        wait_idle();
        repeat (60) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("page_frame_victim_selector verification clean");
        end else begin
            $display("page_frame_victim_selector verification failed");
        end
        $finish;
    end

    initial begin
        #4ms;
        $display("page_frame_victim_selector verification failed");
        $finish;
    end

endmodule

`default_nettype wire
